### hw/rtl/bs_pkg.sv
package bs_pkg;

  localparam int DATA_W = 32;
  localparam int LOG_W  = 3;

  typedef logic signed [DATA_W-1:0] value_t;
  typedef logic [LOG_W-1:0]         log_t;

  localparam log_t LEN_LOG2_RESET = 3'd4;

endpackage

### hw/rtl/bs_front.sv
module bs_front #(
  parameter int MAX_ELEMENTS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  bs_pkg::value_t in_tdata,
  input  logic          cfg_wr_en,
  input  bs_pkg::log_t  cfg_wr_data,
  output logic          push_valid,
  input  logic          push_ready,
  output logic [bs_pkg::DATA_W+bs_pkg::LOG_W+$clog2(MAX_ELEMENTS):0] push_word
);
  import bs_pkg::*;

  localparam int AW      = $clog2(MAX_ELEMENTS);
  localparam int LOG_MAX = $clog2(MAX_ELEMENTS + 1) - 1;

  log_t          len_log2_r;
  logic [AW-1:0] count_r, count_nxt;
  log_t          nlog;
  logic [AW:0]   n_full;
  logic [AW-1:0] last_addr;
  logic          is_last;
  logic          accept;

  // Lengths above the buffer size saturate at the largest power of two that fits.
  assign nlog      = (len_log2_r > log_t'(LOG_MAX)) ? log_t'(LOG_MAX) : len_log2_r;
  assign n_full    = (AW+1)'(1) << nlog;
  assign last_addr = AW'(n_full - (AW+1)'(1));
  assign is_last   = (count_r == last_addr);

  assign in_tready  = push_ready;
  assign push_valid = in_tvalid;
  assign accept     = in_tvalid && push_ready;
  assign push_word  = {in_tdata, nlog, is_last, count_r};

  always_comb begin
    count_nxt = count_r;
    if (cfg_wr_en) begin
      count_nxt = '0;
    end else if (accept) begin
      count_nxt = is_last ? '0 : count_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_log2_r <= LEN_LOG2_RESET;
      count_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        len_log2_r <= cfg_wr_data;
      end
      count_r <= count_nxt;
    end
  end

endmodule

### hw/rtl/bs_queue.sv
module bs_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_word,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_word
);
  import bs_pkg::*;

  logic [WIDTH-1:0] ent_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_word  = ent_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      ent_r[wr_ptr_r] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_rd) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

### hw/rtl/bs_back.sv
module bs_back #(
  parameter int MAX_ELEMENTS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  logic [bs_pkg::DATA_W+bs_pkg::LOG_W+$clog2(MAX_ELEMENTS):0] q_word,
  output logic           out_tvalid,
  input  logic           out_tready,
  output bs_pkg::value_t out_tdata,
  output logic           out_tlast
);
  import bs_pkg::*;

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int QW = DATA_W + LOG_W + 1 + AW;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_WLO  = 3'd2;
  localparam logic [2:0] S_WHI  = 3'd3;
  localparam logic [2:0] S_ERD  = 3'd4;
  localparam logic [2:0] S_EOUT = 3'd5;

  value_t        mem [MAX_ELEMENTS];
  value_t        rd_a_r, rd_b_r;
  value_t        hi_val_r, hi_val_nxt;
  logic [AW-1:0] ra, rb, wa;
  value_t        wd;
  logic          we;

  logic [2:0]    state_r, state_nxt;
  log_t          nlog_r, nlog_nxt;
  log_t          k_r, k_nxt;
  log_t          j_r, j_nxt;
  logic [AW-1:0] p_r, p_nxt;
  logic [AW-1:0] e_r, e_nxt;

  logic          out_valid_r, out_valid_nxt;
  value_t        out_data_r, out_data_nxt;
  logic          out_last_r, out_last_nxt;

  value_t        q_value;
  log_t          q_nlog;
  logic          q_last;
  logic [AW-1:0] q_addr;

  logic [AW:0]   p_ext, lo_full, low_mask, dir_bits, n_full, n_m1;
  logic [AW-1:0] lo, hi, half_last, last_addr;
  logic          ascending;
  logic          swap;
  logic          out_free;

  assign q_addr  = q_word[AW-1:0];
  assign q_last  = q_word[AW];
  assign q_nlog  = q_word[AW+LOG_W:AW+1];
  assign q_value = q_word[QW-1 -: DATA_W];

  // Pair number p becomes the lower index by opening a zero bit at the span position.
  assign p_ext     = {1'b0, p_r};
  assign low_mask  = ~((~(AW+1)'(0)) << j_r);
  assign lo_full   = ((p_ext >> j_r) << (j_r + log_t'(1))) | (p_ext & low_mask);
  assign lo        = lo_full[AW-1:0];
  assign hi        = lo | (AW'(1) << j_r);
  assign dir_bits  = lo_full >> k_r;
  assign ascending = ~dir_bits[0];

  assign n_full    = (AW+1)'(1) << nlog_r;
  assign n_m1      = n_full - (AW+1)'(1);
  assign half_last = AW'(n_m1 >> 1);
  assign last_addr = AW'(n_m1);

  assign swap     = ascending ? (rd_a_r > rd_b_r) : (rd_b_r > rd_a_r);
  assign out_free = !out_valid_r || out_tready;
  assign q_ready  = (state_r == S_LOAD);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a_r <= mem[ra];
    rd_b_r <= mem[rb];
  end

  always_comb begin
    state_nxt     = state_r;
    nlog_nxt      = nlog_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    p_nxt         = p_r;
    e_nxt         = e_r;
    hi_val_nxt    = hi_val_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    ra            = lo;
    rb            = hi;
    wa            = q_addr;
    wd            = q_value;
    we            = 1'b0;

    case (state_r)
      S_LOAD: begin
        if (q_valid) begin
          we = 1'b1;
          if (q_last) begin
            nlog_nxt = q_nlog;
            k_nxt    = log_t'(1);
            j_nxt    = '0;
            p_nxt    = '0;
            e_nxt    = '0;
            state_nxt = (q_nlog == '0) ? S_ERD : S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_WLO;
      end
      S_WLO: begin
        we         = 1'b1;
        wa         = lo;
        wd         = swap ? rd_b_r : rd_a_r;
        hi_val_nxt = swap ? rd_a_r : rd_b_r;
        state_nxt  = S_WHI;
      end
      S_WHI: begin
        we        = 1'b1;
        wa        = hi;
        wd        = hi_val_r;
        state_nxt = S_RD;
        if (p_r == half_last) begin
          p_nxt = '0;
          if (j_r == '0) begin
            if (k_r == nlog_r) begin
              e_nxt     = '0;
              state_nxt = S_ERD;
            end else begin
              k_nxt = k_r + log_t'(1);
              j_nxt = k_r;
            end
          end else begin
            j_nxt = j_r - log_t'(1);
          end
        end else begin
          p_nxt = p_r + AW'(1);
        end
      end
      S_ERD: begin
        ra        = e_r;
        state_nxt = S_EOUT;
      end
      S_EOUT: begin
        ra = e_r;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = rd_a_r;
          out_last_nxt  = (e_r == last_addr);
          if (e_r == last_addr) begin
            state_nxt = S_LOAD;
          end else begin
            e_nxt     = e_r + AW'(1);
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
      nlog_r      <= '0;
      k_r         <= '0;
      j_r         <= '0;
      p_r         <= '0;
      e_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      nlog_r      <= nlog_nxt;
      k_r         <= k_nxt;
      j_r         <= j_nxt;
      p_r         <= p_nxt;
      e_r         <= e_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_val_r   <= hi_val_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

### hw/rtl/bitonic_sorter.sv
// Block sorter: words are loaded one per cycle while the queue has room, and once 2^L
// of them have arrived (L from cfg_wr_data, saturated at the largest power of two not
// above MAX_ELEMENTS) the block is sorted into ascending signed order by a bitonic
// network and sent out, tlast marking the final word of the run. The network runs as
// a sequencer over a buffer memory with two read ports and one write port; each
// compare-exchange steps through a read state, a low-write state and a high-write
// state, and each word is emitted through a read state and an output state that
// waits for the output to be free. A two-word queue sits between the input side and
// the sorting engine, so up to two words are taken while the engine or the output is
// busy. Writing the length register discards a partly loaded block.
module bitonic_sorter #(
  parameter int MAX_ELEMENTS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  bs_pkg::value_t in_tdata,   // [31:0] value
  output logic           out_tvalid,
  input  logic           out_tready,
  output bs_pkg::value_t out_tdata,  // [31:0] sorted_value
  output logic           out_tlast,  // last_of_run
  input  logic           cfg_wr_en,
  input  bs_pkg::log_t   cfg_wr_data // [2:0] length_log2
);
  import bs_pkg::*;

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int QW = DATA_W + LOG_W + 1 + AW;

  logic          push_valid, push_ready;
  logic [QW-1:0] push_word;
  logic          pop_valid, pop_ready;
  logic [QW-1:0] pop_word;

  bs_front #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word)
  );

  bs_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(push_valid),
    .wr_ready(push_ready),
    .wr_word (push_word),
    .rd_valid(pop_valid),
    .rd_ready(pop_ready),
    .rd_word (pop_word)
  );

  bs_back #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_word    (pop_word),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule
